### design/lpws_pkg.sv
// Shared types, constants and helpers for the LCD pixel write sequencer.
package lpws_pkg;

    // Field widths
    localparam int COORD_W = 16;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 8'd1;

    // Reset values
    localparam logic [COORD_W-1:0] RESET_WIDTH  = 16'd320;
    localparam logic [COORD_W-1:0] RESET_HEIGHT = 16'd240;
    localparam logic [COORD_W-1:0] CACHE_EMPTY  = 16'hFFFF;

    // Display controller commands
    localparam logic [BYTE_W-1:0] CMD_COLUMN_SET   = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_ROW_SET      = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_MEMORY_WRITE = 8'h2C;

    // Job queue sizing
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified pixel waiting to be sent
    typedef struct packed {
        logic               set_col;
        logic               set_row;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] colour;
    } t_job;

    // Byte sequencer steps
    typedef enum logic [3:0] {
        ST_COL_CMD,
        ST_COL_SH,
        ST_COL_SL,
        ST_COL_EH,
        ST_COL_EL,
        ST_ROW_CMD,
        ST_ROW_SH,
        ST_ROW_SL,
        ST_ROW_EH,
        ST_ROW_EL,
        ST_MEM_CMD,
        ST_PIX_H,
        ST_PIX_L
    } t_step;

    // Entry step of a job
    function automatic t_step first_step(input t_job job);
        t_step s;
        if (job.set_col) begin
            s = ST_COL_CMD;
        end else if (job.set_row) begin
            s = ST_ROW_CMD;
        end else begin
            s = ST_MEM_CMD;
        end
        return s;
    endfunction

endpackage

### design/lpws_pixel_if.sv
// Pixel input channel.
interface lpws_pixel_if;
    import lpws_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] colour;

    modport source (output valid, output column, output row, output colour, input ready);
    modport sink   (input valid, input column, input row, input colour, output ready);
endinterface

### design/lpws_byte_if.sv
// Display byte output channel.
interface lpws_byte_if;
    import lpws_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_data;
    logic              last;

    modport source (output valid, output out_byte, output is_data, output last, input ready);
    modport sink   (input valid, input out_byte, input is_data, input last, output ready);
endinterface

### design/lpws_cfg_if.sv
// Configuration write channel.
interface lpws_cfg_if;
    import lpws_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/lpws_front.sv
// Front end: screen size registers, range check and address window cache.
module lpws_front
    import lpws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpws_pixel_if.sink  i_pixel,
    lpws_cfg_if.sink    i_cfg,
    output logic        o_push_valid,
    input  logic        i_push_ready,
    output t_job        o_push_data
);

    logic [COORD_W-1:0] r_width;
    logic [COORD_W-1:0] r_height;
    logic [COORD_W-1:0] r_cached_column;
    logic [COORD_W-1:0] r_cached_row;

    logic in_fire;
    logic in_range;
    logic col_miss;
    logic row_miss;

    // Take configuration writes at any time
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_SCREEN_WIDTH) begin
                r_width <= i_cfg.data;
            end
            if (i_cfg.index == CFG_SCREEN_HEIGHT) begin
                r_height <= i_cfg.data;
            end
        end
    end

    // Classify the incoming pixel
    assign in_range = (i_pixel.column < r_width) && (i_pixel.row < r_height);
    assign col_miss = i_pixel.column != r_cached_column;
    assign row_miss = i_pixel.row != r_cached_row;

    assign i_pixel.ready = i_push_ready;
    assign in_fire       = i_pixel.valid && i_push_ready;

    assign o_push_valid        = i_pixel.valid && in_range;
    assign o_push_data.set_col = col_miss;
    assign o_push_data.set_row = row_miss;
    assign o_push_data.column  = i_pixel.column;
    assign o_push_data.row     = i_pixel.row;
    assign o_push_data.colour  = i_pixel.colour;

    // Advance the window cache as each in-range pixel is queued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cached_column <= CACHE_EMPTY;
            r_cached_row    <= CACHE_EMPTY;
        end else if (in_fire && in_range) begin
            r_cached_column <= i_pixel.column;
            r_cached_row    <= i_pixel.row;
        end
    end

    a_cache_tracks_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && in_range) |=> (r_cached_column == $past(i_pixel.column)
                                   && r_cached_row == $past(i_pixel.row)))
        else $error("window cache did not follow an accepted pixel");

    a_out_of_range_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !in_range) |=> ($stable(r_cached_column) && $stable(r_cached_row)))
        else $error("out-of-range pixel disturbed the window cache");

endmodule

### design/lpws_queue.sv
// Short job queue between front end and byte sequencer.
module lpws_queue
    import lpws_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_job  i_push_data,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_job  o_pop_data
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wptr;
    logic [QPTR_W-1:0] n_rptr;
    logic [QCNT_W-1:0] n_count;

    logic push;
    logic pop;

    assign o_push_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("job queue overfilled");

endmodule

### design/lpws_back.sv
// Back end: steps through one job's command and data bytes into an output register.
module lpws_back
    import lpws_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_pop_valid,
    output logic         o_pop_ready,
    input  t_job         i_pop_data,
    lpws_byte_if.source  o_byte
);

    t_job              r_job;
    t_step             r_step;
    logic              r_busy;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_is_data;
    logic              r_out_last;

    t_job              n_job;
    t_step             n_step;
    logic              n_busy;

    t_job              cur_job;
    t_step             cur_step;
    t_step             step_after;
    logic              out_free;
    logic              adv;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_is_data;
    logic              emit_last;

    // Pick the job in hand, or the queue head when free
    assign out_free    = !r_out_valid || o_byte.ready;
    assign cur_job     = r_busy ? r_job : i_pop_data;
    assign cur_step    = r_busy ? r_step : first_step(i_pop_data);
    assign adv         = out_free && (r_busy || i_pop_valid);
    assign o_pop_ready = out_free && !r_busy;

    // Next step of the sequence
    always_comb begin
        unique case (cur_step)
            ST_COL_CMD: step_after = ST_COL_SH;
            ST_COL_SH:  step_after = ST_COL_SL;
            ST_COL_SL:  step_after = ST_COL_EH;
            ST_COL_EH:  step_after = ST_COL_EL;
            ST_COL_EL:  step_after = cur_job.set_row ? ST_ROW_CMD : ST_MEM_CMD;
            ST_ROW_CMD: step_after = ST_ROW_SH;
            ST_ROW_SH:  step_after = ST_ROW_SL;
            ST_ROW_SL:  step_after = ST_ROW_EH;
            ST_ROW_EH:  step_after = ST_ROW_EL;
            ST_ROW_EL:  step_after = ST_MEM_CMD;
            ST_MEM_CMD: step_after = ST_PIX_H;
            ST_PIX_H:   step_after = ST_PIX_L;
            ST_PIX_L:   step_after = ST_COL_CMD;
            default:    step_after = ST_COL_CMD;
        endcase
    end

    always_comb begin
        n_job  = r_job;
        n_step = r_step;
        n_busy = r_busy;
        if (adv) begin
            n_job  = cur_job;
            n_step = step_after;
            n_busy = cur_step != ST_PIX_L;
        end
    end

    // Byte and flags for the current step
    always_comb begin
        emit_is_data = 1'b1;
        emit_last    = 1'b0;
        unique case (cur_step)
            ST_COL_CMD: begin
                emit_byte    = CMD_COLUMN_SET;
                emit_is_data = 1'b0;
            end
            ST_COL_SH, ST_COL_EH: emit_byte = cur_job.column[15:8];
            ST_COL_SL, ST_COL_EL: emit_byte = cur_job.column[7:0];
            ST_ROW_CMD: begin
                emit_byte    = CMD_ROW_SET;
                emit_is_data = 1'b0;
            end
            ST_ROW_SH, ST_ROW_EH: emit_byte = cur_job.row[15:8];
            ST_ROW_SL, ST_ROW_EL: emit_byte = cur_job.row[7:0];
            ST_MEM_CMD: begin
                emit_byte    = CMD_MEMORY_WRITE;
                emit_is_data = 1'b0;
            end
            ST_PIX_H:   emit_byte = cur_job.colour[15:8];
            ST_PIX_L: begin
                emit_byte = cur_job.colour[7:0];
                emit_last = 1'b1;
            end
            default: begin
                emit_byte    = CMD_MEMORY_WRITE;
                emit_is_data = 1'b0;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_COL_CMD;
            r_busy <= 1'b0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    // Load the output register, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte    <= emit_byte;
            r_out_is_data <= emit_is_data;
            r_out_last    <= emit_last;
        end
    end

    assign o_byte.valid    = r_out_valid;
    assign o_byte.out_byte = r_out_byte;
    assign o_byte.is_data  = r_out_is_data;
    assign o_byte.last     = r_out_last;

    a_busy_not_at_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step != ST_COL_CMD))
        else $error("job in hand parked at its entry step");

    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> r_out_is_data)
        else $error("final byte flagged as command");

endmodule

### design/lcd_pixel_write_sequencer_unit.sv
// Top level of the LCD pixel write sequencer.
//
//  Channel   Dir  Payload                        Handshake
//  i_pixel   in   column, row, colour (16b each)  valid / ready
//  i_cfg     in   index (8b), data (16b)          valid / ready (always ready)
//  o_byte    out  out_byte (8b), is_data, last    valid / ready
//
// A pixel yields 3, 8 or 13 bytes, none when off screen; the byte sequencer sets the rate.
// Pixels are taken back to back while the two-entry job queue has room.
// The first byte of a job is loaded from the queue head into the output register when that register is free.
// Synchronous active-low reset; screen size resets to 320 x 240, window cache to all ones.
// A stall on o_byte holds the sequencer and backs up into the queue and i_pixel.
module lcd_pixel_write_sequencer_unit
    import lpws_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpws_pixel_if.sink   i_pixel,
    lpws_cfg_if.sink     i_cfg,
    lpws_byte_if.source  o_byte
);

    logic push_valid;
    logic push_ready;
    t_job push_data;
    logic pop_valid;
    logic pop_ready;
    t_job pop_data;

    lpws_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pixel      (i_pixel),
        .i_cfg        (i_cfg),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    lpws_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    lpws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_byte      (o_byte)
    );

endmodule

### tb/lcd_pixel_write_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LCD pixel write sequencer: directed table plus random pixels.
module lcd_pixel_write_sequencer_unit_tb;
    import lpws_pkg::*;

    localparam int PREDICT        = -1;   // typed length meaning "use the predictor"
    localparam int DRAIN_CYCLES   = 8;    // quiet cycles before a register write
    localparam int SETTLE_CYCLES  = 20;   // quiet cycles before the verdict
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_SHOWN      = 10;
    localparam int PHASE_ITEMS    = 46;

    // Register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} t_row_kind;

    // One display byte as it leaves the block
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              is_data;
        logic              last;
    } t_lcd_byte;

    // One line of the directed table; typed bytes are right-aligned, first byte highest
    typedef struct packed {
        t_row_kind          kind;
        logic [COORD_W-1:0] col_or_index;
        logic [COORD_W-1:0] row_or_data;
        logic [COORD_W-1:0] colour;
        int                 typed_len;
        logic [103:0]       typed_bytes;
        logic [12:0]        typed_dc;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lpws_pixel_if pixel_ch ();
    lpws_cfg_if   cfg_ch ();
    lpws_byte_if  byte_ch ();

    lcd_pixel_write_sequencer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pixel (pixel_ch),
        .i_cfg   (cfg_ch),
        .o_byte  (byte_ch)
    );

    // Predictor state
    logic [COORD_W-1:0] model_width;
    logic [COORD_W-1:0] model_height;
    logic [COORD_W-1:0] cached_col;
    logic [COORD_W-1:0] cached_row;
    t_lcd_byte          burst [13];
    int                 burst_len;

    t_lcd_byte pending_bytes [$];
    t_stim_row directed_rows [$];

    int gap_max;
    int stall_max;
    int stall_left;
    int fail_count;
    int idle_cycles;

    always #2 i_clk = ~i_clk;

    // Predictor: build the byte burst of one pixel and update the window cache
    function automatic void add_byte(input logic [BYTE_W-1:0] value, input logic is_data);
        burst[burst_len] = {value, is_data, 1'b0};
        burst_len++;
    endfunction

    function automatic void add_range(input logic [BYTE_W-1:0] command,
                                      input logic [COORD_W-1:0] coord);
        add_byte(command, 1'b0);
        repeat (2) begin
            add_byte(coord[15:8], 1'b1);
            add_byte(coord[7:0], 1'b1);
        end
    endfunction

    function automatic void predict_pixel_bytes(input logic [COORD_W-1:0] col,
                                                input logic [COORD_W-1:0] row,
                                                input logic [COORD_W-1:0] colour);
        burst_len = 0;
        if (col >= model_width || row >= model_height) begin
            return;
        end
        if (col != cached_col) begin
            add_range(CMD_COLUMN_SET, col);
            cached_col = col;
        end
        if (row != cached_row) begin
            add_range(CMD_ROW_SET, row);
            cached_row = row;
        end
        add_byte(CMD_MEMORY_WRITE, 1'b0);
        add_byte(colour[15:8], 1'b1);
        add_byte(colour[7:0], 1'b1);
    endfunction

    // Directed table builders
    function automatic void add_pixel(input logic [COORD_W-1:0] col,
                                      input logic [COORD_W-1:0] row,
                                      input logic [COORD_W-1:0] colour,
                                      input int typed_len,
                                      input logic [103:0] typed_bytes,
                                      input logic [12:0] typed_dc);
        t_stim_row r;
        r = {ROW_PIXEL, col, row, colour, typed_len, typed_bytes, typed_dc};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] index,
                                      input logic [COORD_W-1:0] value);
        t_stim_row r;
        r = {ROW_WRITE, 16'(index), value, 16'h0, PREDICT, 104'h0, 13'h0};
        directed_rows.push_back(r);
    endfunction

    // Mostly reuse the cached coordinate or stay in range, sometimes go anywhere
    function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] held,
                                                      input logic [COORD_W-1:0] limit);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return held;
        end
        if (r < 85) begin
            return 16'($urandom_range(0, limit - 1));
        end
        return 16'($urandom);
    endfunction

    // Offer one pixel after a random gap; called and left at a falling edge
    task automatic send_pixel(input logic [COORD_W-1:0] col,
                              input logic [COORD_W-1:0] row,
                              input logic [COORD_W-1:0] colour,
                              input int typed_len,
                              input logic [103:0] typed_bytes,
                              input logic [12:0] typed_dc);
        int gap;
        int k;
        t_lcd_byte entry;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pixel_ch.valid  <= 1'b1;
        pixel_ch.column <= col;
        pixel_ch.row    <= row;
        pixel_ch.colour <= colour;
        do @(posedge i_clk); while (!pixel_ch.ready);
        predict_pixel_bytes(col, row, colour);
        if (typed_len != PREDICT) begin
            burst_len = typed_len;
            for (k = 0; k < typed_len; k++) begin
                burst[k] = {typed_bytes[8*(typed_len-1-k) +: 8], typed_dc[typed_len-1-k], 1'b0};
            end
        end
        for (k = 0; k < burst_len; k++) begin
            entry = burst[k];
            entry.last = (k == burst_len - 1);
            pending_bytes.push_back(entry);
        end
        @(negedge i_clk);
    endtask

    // Write a register once the block has gone quiet
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [COORD_W-1:0] value);
        pixel_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (index == CFG_SCREEN_WIDTH) begin
            model_width = value;
        end else if (index == CFG_SCREEN_HEIGHT) begin
            model_height = value;
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold ready low for the drawn stall, then raise it
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            byte_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            byte_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted byte with the oldest expectation
    always @(posedge i_clk) begin
        t_lcd_byte got;
        t_lcd_byte want;
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            got = {byte_ch.out_byte, byte_ch.is_data, byte_ch.last};
            stall_left = $urandom_range(0, stall_max);
            if (pending_bytes.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN) begin
                    $display("unexpected byte: got %h is_data %b last %b, expected none",
                             got.value, got.is_data, got.last);
                end
            end else begin
                want = pending_bytes.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN) begin
                        $display("byte mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 want.value, want.is_data, want.last,
                                 got.value, got.is_data, got.last);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((pixel_ch.valid && pixel_ch.ready) || (byte_ch.valid && byte_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_stim_row r;
        int phase;
        int counted;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;

        pixel_ch.valid  = 1'b0;
        pixel_ch.column = '0;
        pixel_ch.row    = '0;
        pixel_ch.colour = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        byte_ch.ready   = 1'b0;
        stall_left      = 0;
        fail_count      = 0;
        idle_cycles     = 0;
        gap_max         = 3;
        stall_max       = 3;

        model_width  = RESET_WIDTH;
        model_height = RESET_HEIGHT;
        cached_col   = CACHE_EMPTY;
        cached_row   = CACHE_EMPTY;

        // Directed table
        // first pixel after reset sets both coordinates
        add_pixel(16'd0, 16'd0, 16'hFFFF, 13,
                  104'h2A_0000_0000_2B_0000_0000_2C_FFFF, 13'b0_1111_0_1111_0_11);
        // both coordinates cached
        add_pixel(16'd0, 16'd0, 16'h0000, 3, 104'h2C_0000, 13'b0_11);
        // last column in range, row still cached
        add_pixel(16'd319, 16'd0, 16'h1234, 8, 104'h2A_013F_013F_2C_1234, 13'b0_1111_0_11);
        // column on the width edge
        add_pixel(16'd320, 16'd0, 16'hBEEF, 0, 104'h0, 13'h0);
        add_pixel(16'd319, 16'd239, 16'hABCD, 8, 104'h2B_00EF_00EF_2C_ABCD, 13'b0_1111_0_11);
        // row on the height edge
        add_pixel(16'd0, 16'd240, 16'h0001, 0, 104'h0, 13'h0);
        // all-ones coordinates never fit
        add_pixel(16'hFFFF, 16'hFFFF, 16'h8000, 0, 104'h0, 13'h0);
        // largest screen
        add_write(CFG_SCREEN_WIDTH, 16'hFFFF);
        add_write(CFG_SCREEN_HEIGHT, 16'hFFFF);
        add_pixel(16'hFFFE, 16'hFFFE, 16'hFFFF, 13,
                  104'h2A_FFFE_FFFE_2B_FFFE_FFFE_2C_FFFF, 13'b0_1111_0_1111_0_11);
        add_pixel(16'hFFFF, 16'h0000, 16'h0000, 0, 104'h0, 13'h0);
        add_pixel(16'h0000, 16'hFFFF, 16'h0000, 0, 104'h0, 13'h0);
        // writes to unused indexes change nothing
        add_write(CFG_UNUSED_LO, 16'h0000);
        add_write(CFG_UNUSED_HI, 16'h0001);
        add_pixel(16'd1, 16'd1, 16'h5555, PREDICT, 104'h0, 13'h0);
        // zero width, then zero height, swallow every pixel
        add_write(CFG_SCREEN_WIDTH, 16'h0000);
        add_pixel(16'd0, 16'd0, 16'h1111, 0, 104'h0, 13'h0);
        add_write(CFG_SCREEN_WIDTH, 16'h0001);
        add_write(CFG_SCREEN_HEIGHT, 16'h0000);
        add_pixel(16'd0, 16'd0, 16'h2222, 0, 104'h0, 13'h0);
        // one-pixel screen
        add_write(CFG_SCREEN_HEIGHT, 16'h0001);
        add_pixel(16'd0, 16'd0, 16'hAAAA, 13,
                  104'h2A_0000_0000_2B_0000_0000_2C_AAAA, 13'b0_1111_0_1111_0_11);
        add_pixel(16'd0, 16'd0, 16'h8001, 3, 104'h2C_8001, 13'b0_11);
        add_pixel(16'd1, 16'd0, 16'h7777, 0, 104'h0, 13'h0);
        add_pixel(16'd0, 16'd1, 16'h7777, 0, 104'h0, 13'h0);
        add_write(CFG_SCREEN_WIDTH, RESET_WIDTH);
        add_write(CFG_SCREEN_HEIGHT, RESET_HEIGHT);
        add_pixel(16'd7, 16'd0, 16'h0F0F, PREDICT, 104'h0, 13'h0);
        add_pixel(16'd7, 16'd5, 16'hF0F0, PREDICT, 104'h0, 13'h0);

        // Release reset at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.kind == ROW_WRITE) begin
                write_register(r.col_or_index[CFG_IDX_W-1:0], r.row_or_data);
            end else begin
                send_pixel(r.col_or_index, r.row_or_data, r.colour,
                           r.typed_len, r.typed_bytes, r.typed_dc);
            end
        end

        // Random phases, each under its own screen size and idling pattern
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_register(CFG_SCREEN_WIDTH, RESET_WIDTH);
                    write_register(CFG_SCREEN_HEIGHT, RESET_HEIGHT);
                    gap_max = 6;
                    stall_max = 6;
                end
                1: begin
                    write_register(CFG_SCREEN_WIDTH, 16'hFFFF);
                    write_register(CFG_SCREEN_HEIGHT, 16'hFFFF);
                    gap_max = 0;
                    stall_max = 0;
                end
                2: begin
                    write_register(CFG_SCREEN_WIDTH, 16'd1);
                    write_register(CFG_SCREEN_HEIGHT, 16'd1);
                    gap_max = 6;
                    stall_max = 0;
                end
                3: begin
                    write_register(CFG_SCREEN_WIDTH, 16'd16);
                    write_register(CFG_SCREEN_HEIGHT, 16'd4);
                    gap_max = 0;
                    stall_max = 6;
                end
                4: begin
                    write_register(CFG_SCREEN_WIDTH, 16'($urandom_range(1, 65535)));
                    write_register(CFG_SCREEN_HEIGHT, 16'($urandom_range(1, 65535)));
                    gap_max = 6;
                    stall_max = 6;
                end
                default: begin
                    write_register(CFG_SCREEN_WIDTH, 16'hFFFF);
                    write_register(CFG_SCREEN_HEIGHT, 16'd2);
                    gap_max = 6;
                    stall_max = 6;
                end
            endcase
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                col = pick_coord(cached_col, model_width);
                row = pick_coord(cached_row, model_height);
                send_pixel(col, row, 16'($urandom), PREDICT, 104'h0, 13'h0);
                counted++;
            end
        end

        // Drain and settle
        pixel_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
design/lpws_pkg.sv
design/lpws_pixel_if.sv
design/lpws_byte_if.sv
design/lpws_cfg_if.sv
design/lpws_front.sv
design/lpws_queue.sv
design/lpws_back.sv
design/lcd_pixel_write_sequencer_unit.sv
tb/lcd_pixel_write_sequencer_unit_tb.sv
